// ----- src/two_bone_vertex_skinning_top_defines.svh -----
// ---------------------------------------------------------------------------
// Two-bone vertex skinning: assertion macros
// Shared concurrent assertion forms, clocked on clk and disabled in reset.
// ---------------------------------------------------------------------------
`ifndef TWO_BONE_VERTEX_SKINNING_TOP_DEFINES_SVH
`define TWO_BONE_VERTEX_SKINNING_TOP_DEFINES_SVH

// Same-cycle implication.
`define TBVS_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("same-cycle check failed");

// Next-cycle implication.
`define TBVS_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`endif

// ----- src/tbvs_pkg.sv -----
// ---------------------------------------------------------------------------
// Two-bone vertex skinning package
// Types, codes and saturation helper shared by the skinning pipeline.
// ---------------------------------------------------------------------------
package tbvs_pkg;

    localparam int ELEM_COUNT = 13;
    localparam logic       KIND_SKIN  = 1'b0;
    localparam logic       KIND_WRITE = 1'b1;
    localparam logic [3:0] ELEM_SCALE = 4'd12;
    localparam logic [16:0] WEIGHT_ONE = 17'd65536;
    localparam logic signed [63:0] SAT_MAX = 64'sh0000_0000_7fff_ffff;
    localparam logic signed [63:0] SAT_MIN = 64'shffff_ffff_8000_0000;

    typedef logic [2:0][31:0] vec3_t;

    typedef struct packed {
        logic [8:0][31:0] rot;
        logic [2:0][31:0] pos;
        logic [31:0]      scale;
    } bone_t;

    typedef struct packed {
        logic        en;
        logic [3:0]  sel;
        logic [31:0] data;
    } wr_t;

    typedef struct packed {
        logic        no_major;
        logic        use_minor;
        logic [16:0] w;
        vec3_t       dmaj;
        vec3_t       dmin;
    } side_t;

    function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
        if (v > SAT_MAX) begin
            return 32'sh7fff_ffff;
        end
        else if (v < SAT_MIN) begin
            return 32'sh8000_0000;
        end
        return v[31:0];
    endfunction

endpackage

// ----- src/tbvs_in_if.sv -----
// ---------------------------------------------------------------------------
// Vertex input channel
// Valid/ready channel carrying one vertex or one palette write.
// ---------------------------------------------------------------------------
interface tbvs_in_if;
    logic               valid;
    logic               ready;
    logic               kind;
    logic signed [6:0]  primary_bone;
    logic signed [6:0]  secondary_bone;
    logic [3:0]         element_select;
    logic signed [31:0] major_dx;
    logic signed [31:0] major_dy;
    logic signed [31:0] major_dz;
    logic signed [31:0] minor_dx;
    logic signed [31:0] minor_dy;
    logic signed [31:0] minor_dz;
    logic [16:0]        blend_factor;

    modport source (output valid, kind, primary_bone, secondary_bone, element_select,
                    major_dx, major_dy, major_dz, minor_dx, minor_dy, minor_dz,
                    blend_factor, input ready);
    modport sink (input valid, kind, primary_bone, secondary_bone, element_select,
                  major_dx, major_dy, major_dz, minor_dx, minor_dy, minor_dz,
                  blend_factor, output ready);
endinterface

// ----- src/tbvs_out_if.sv -----
// ---------------------------------------------------------------------------
// Skinned position channel
// Valid/ready channel carrying one skinned position.
// ---------------------------------------------------------------------------
interface tbvs_out_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] pos_z;

    modport source (output valid, pos_x, pos_y, pos_z, input ready);
    modport sink (input valid, pos_x, pos_y, pos_z, output ready);
endinterface

// ----- src/tbvs_palette.sv -----
// ---------------------------------------------------------------------------
// Bone palette
// Two copies of the palette, one per read port, written together.
// ---------------------------------------------------------------------------
module tbvs_palette
    import tbvs_pkg::*;
#(
    parameter int BONE_COUNT = 64,
    parameter int IDX_W = 6
)
(
    input  logic             clk,
    input  logic             en,
    input  wr_t              wr,
    input  logic [IDX_W-1:0] wr_idx,
    input  logic [IDX_W-1:0] maj_idx,
    input  logic [IDX_W-1:0] min_idx,
    output bone_t            maj_bone,
    output bone_t            min_bone
);

    logic [31:0] maj_mem [ELEM_COUNT][BONE_COUNT];
    logic [31:0] min_mem [ELEM_COUNT][BONE_COUNT];
    logic [ELEM_COUNT-1:0][31:0] maj_rd_reg;
    logic [ELEM_COUNT-1:0][31:0] min_rd_reg;

    always_ff @(posedge clk)
    begin
        if (wr.en)
        begin
            maj_mem[wr.sel][wr_idx] <= wr.data;
            min_mem[wr.sel][wr_idx] <= wr.data;
        end
        if (en)
        begin
            for (int e = 0; e < ELEM_COUNT; e++)
            begin
                maj_rd_reg[e] <= maj_mem[e][maj_idx];
                min_rd_reg[e] <= min_mem[e][min_idx];
            end
        end
    end

    always_comb
    begin
        for (int r = 0; r < 9; r++)
        begin
            maj_bone.rot[r] = maj_rd_reg[r];
            min_bone.rot[r] = min_rd_reg[r];
        end
        for (int k = 0; k < 3; k++)
        begin
            maj_bone.pos[k] = maj_rd_reg[9 + k];
            min_bone.pos[k] = min_rd_reg[9 + k];
        end
        maj_bone.scale = maj_rd_reg[ELEM_COUNT-1];
        min_bone.scale = min_rd_reg[ELEM_COUNT-1];
    end

endmodule

// ----- src/tbvs_bone_xform.sv -----
// ---------------------------------------------------------------------------
// Bone transform
// Four-stage scale, rotate and translate of one offset by one bone.
// ---------------------------------------------------------------------------
module tbvs_bone_xform
    import tbvs_pkg::*;
(
    input  logic  clk,
    input  logic  en,
    input  bone_t bone,
    input  vec3_t d,
    output vec3_t p
);

    logic signed [63:0] prod_s_reg [3];
    logic signed [63:0] prod_s_next [3];
    logic [8:0][31:0]   rot2_reg;
    logic [8:0][31:0]   rot3_reg;
    logic [2:0][31:0]   pos2_reg;
    logic [2:0][31:0]   pos3_reg;
    logic [2:0][31:0]   pos4_reg;
    logic signed [31:0] f_reg [3];
    logic signed [31:0] f_next [3];
    logic signed [63:0] prod_r_reg [9];
    logic signed [63:0] prod_r_next [9];
    logic signed [31:0] p_reg [3];
    logic signed [31:0] p_next [3];

    always_comb
    begin
        logic signed [63:0] t;
        logic signed [49:0] acc;
        for (int c = 0; c < 3; c++)
        begin
            prod_s_next[c] = $signed(d[c]) * $signed(bone.scale);
            t = prod_s_reg[c] + 64'sd32768;
            f_next[c] = sat32(64'($signed(t[63:16])));
        end
        for (int i = 0; i < 9; i++)
        begin
            prod_r_next[i] = f_reg[i % 3] * $signed(rot3_reg[i]);
        end
        for (int r = 0; r < 3; r++)
        begin
            acc = 50'($signed(pos4_reg[r]));
            for (int c = 0; c < 3; c++)
            begin
                t = prod_r_reg[r * 3 + c] + 64'sd32768;
                acc = acc + 50'($signed(t[63:16]));
            end
            p_next[r] = sat32(64'(acc));
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            prod_s_reg <= prod_s_next;
            rot2_reg   <= bone.rot;
            pos2_reg   <= bone.pos;
            f_reg      <= f_next;
            rot3_reg   <= rot2_reg;
            pos3_reg   <= pos2_reg;
            prod_r_reg <= prod_r_next;
            pos4_reg   <= pos3_reg;
            p_reg      <= p_next;
        end
    end

    always_comb
    begin
        for (int r = 0; r < 3; r++)
        begin
            p[r] = p_reg[r];
        end
    end

endmodule

// ----- src/tbvs_blend.sv -----
// ---------------------------------------------------------------------------
// Bone blend
// Two-stage weighted blend of the major and minor points with selection.
// ---------------------------------------------------------------------------
module tbvs_blend
    import tbvs_pkg::*;
(
    input  logic  clk,
    input  logic  en,
    input  side_t side,
    input  vec3_t pmaj,
    input  vec3_t pmin,
    output vec3_t res
);

    logic signed [50:0] prod_reg [3];
    logic signed [50:0] prod_next [3];
    vec3_t              pmaj_reg;
    vec3_t              pmin_reg;
    vec3_t              raw_reg;
    logic               no_major_reg;
    logic               use_minor_reg;
    vec3_t              res_reg;
    vec3_t              res_next;

    always_comb
    begin
        logic signed [32:0] diff;
        logic signed [17:0] ws;
        logic signed [50:0] t;
        logic signed [35:0] sum;
        ws = $signed({1'b0, side.w});
        for (int k = 0; k < 3; k++)
        begin
            diff = 33'($signed(pmaj[k])) - 33'($signed(pmin[k]));
            prod_next[k] = diff * ws;
            t = prod_reg[k] + 51'sd32768;
            sum = 36'($signed(t[50:16])) + 36'($signed(pmin_reg[k]));
            if (no_major_reg)
            begin
                res_next[k] = raw_reg[k];
            end
            else if (!use_minor_reg)
            begin
                res_next[k] = pmaj_reg[k];
            end
            else
            begin
                res_next[k] = sat32(64'(sum));
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            prod_reg      <= prod_next;
            pmaj_reg      <= pmaj;
            pmin_reg      <= pmin;
            raw_reg       <= side.dmaj;
            no_major_reg  <= side.no_major;
            use_minor_reg <= side.use_minor;
            res_reg       <= res_next;
        end
    end

    assign res = res_reg;

endmodule

// ----- src/two_bone_vertex_skinning_top.sv -----
// ---------------------------------------------------------------------------
// Two-bone vertex skinning engine
// Loadable bone palette and a seven-stage linear blend skinning pipeline.
// ---------------------------------------------------------------------------
// The vtx channel carries either a palette write (kind one) or a vertex to
// skin (kind zero). A palette write to an in-range bone and element stores
// one element of that bone at the edge of its transfer. No palette write
// produces a result; a vertex issued in the next cycle already sees a stored
// value. Every vertex produces one position on the res channel.
// From a vertex transfer to its result being valid, the stages are:
// palette read, offset scaling, scale rounding, rotation products, sum and
// translate, blend product, and blend round with final selection.
// Throughput is one item per cycle while res is not stalled; each multiply stage holds its own
// multipliers, so nothing is shared between items.
// Reset clears the stage valid bits only. The palette has no reset; a bone
// must be written before any vertex uses it.
// When the receiver stalls with a result waiting, the whole pipeline holds
// and vtx.ready drops in the same cycle, so no item is lost or repeated.
// ---------------------------------------------------------------------------
`include "two_bone_vertex_skinning_top_defines.svh"

module two_bone_vertex_skinning_top
    import tbvs_pkg::*;
#(
    parameter int BONE_COUNT = 64
)
(
    input  logic clk,
    input  logic rst_n,
    tbvs_in_if.sink    vtx,
    tbvs_out_if.source res
);

    localparam int IDX_W = $clog2(BONE_COUNT);
    localparam int STAGES = 7;

    logic             en;
    logic             maj_ok;
    logic             min_ok;
    logic [16:0]      w_clamp;
    wr_t              wr;
    logic [IDX_W-1:0] maj_idx;
    logic [IDX_W-1:0] min_idx;
    bone_t            maj_bone;
    bone_t            min_bone;
    side_t            side_next;
    side_t            side_reg [5];
    logic [STAGES-1:0] v_reg;
    logic [STAGES-1:0] v_next;
    vec3_t            pmaj;
    vec3_t            pmin;
    vec3_t            res_vec;

    assign en = !v_reg[STAGES-1] || res.ready;
    assign vtx.ready = en;

    assign maj_ok = !vtx.primary_bone[6] && (int'(vtx.primary_bone) < BONE_COUNT);
    assign min_ok = !vtx.secondary_bone[6] && (int'(vtx.secondary_bone) < BONE_COUNT);
    assign maj_idx = IDX_W'(vtx.primary_bone[5:0]);
    assign min_idx = IDX_W'(vtx.secondary_bone[5:0]);
    assign w_clamp = (vtx.blend_factor > WEIGHT_ONE) ? WEIGHT_ONE : vtx.blend_factor;

    assign wr.en = vtx.valid && en && (vtx.kind == KIND_WRITE) && maj_ok
                   && (vtx.element_select <= ELEM_SCALE);
    assign wr.sel = vtx.element_select;
    assign wr.data = vtx.major_dx;

    always_comb
    begin
        side_next.no_major  = !maj_ok;
        side_next.use_minor = min_ok && (w_clamp != WEIGHT_ONE);
        side_next.w         = w_clamp;
        side_next.dmaj      = {vtx.major_dz, vtx.major_dy, vtx.major_dx};
        side_next.dmin      = {vtx.minor_dz, vtx.minor_dy, vtx.minor_dx};
        v_next = {v_reg[STAGES-2:0], vtx.valid && (vtx.kind == KIND_SKIN)};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else if (en)
        begin
            v_reg <= v_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            side_reg[0] <= side_next;
            for (int s = 1; s < 5; s++)
            begin
                side_reg[s] <= side_reg[s-1];
            end
        end
    end

    tbvs_palette #(
        .BONE_COUNT (BONE_COUNT),
        .IDX_W      (IDX_W)
    ) u_palette (
        .clk      (clk),
        .en       (en),
        .wr       (wr),
        .wr_idx   (maj_idx),
        .maj_idx  (maj_idx),
        .min_idx  (min_idx),
        .maj_bone (maj_bone),
        .min_bone (min_bone)
    );

    tbvs_bone_xform u_xform_maj (
        .clk  (clk),
        .en   (en),
        .bone (maj_bone),
        .d    (side_reg[0].dmaj),
        .p    (pmaj)
    );

    tbvs_bone_xform u_xform_min (
        .clk  (clk),
        .en   (en),
        .bone (min_bone),
        .d    (side_reg[0].dmin),
        .p    (pmin)
    );

    tbvs_blend u_blend (
        .clk  (clk),
        .en   (en),
        .side (side_reg[4]),
        .pmaj (pmaj),
        .pmin (pmin),
        .res  (res_vec)
    );

    assign res.valid = v_reg[STAGES-1];
    assign res.pos_x = res_vec[0];
    assign res.pos_y = res_vec[1];
    assign res.pos_z = res_vec[2];

    // A palette write never enters the result pipeline; a vertex always does.
    `TBVS_ASSERT_NXT(a_write_no_result, vtx.valid && vtx.ready && vtx.kind, !v_reg[0])
    `TBVS_ASSERT_NXT(a_skin_enters, vtx.valid && vtx.ready && !vtx.kind, v_reg[0])
    // A stalled pipeline keeps every stage valid bit.
    `TBVS_ASSERT_NXT(a_stall_holds, !en, $stable(v_reg))

endmodule

// ----- sim/two_bone_vertex_skinning_checker.sv -----
// ---------------------------------------------------------------------------
// Two-bone vertex skinning checker
// Watches both channels, keeps a shadow bone palette, predicts each skinned
// position in Q16.16 and compares it with the result stream in order.
// ---------------------------------------------------------------------------
module two_bone_vertex_skinning_checker
    import tbvs_pkg::*;
#(
    parameter int BONE_COUNT = 64
)
(
    input  logic clk,
    input  logic rst_n,
    tbvs_in_if   vtx,
    tbvs_out_if  res,
    output int   mismatches,
    output int   outstanding
);

    typedef longint xyz_t [3];

    typedef struct {
        logic signed [31:0] x;
        logic signed [31:0] y;
        logic signed [31:0] z;
    } position_t;

    logic [31:0] shadow_rot   [BONE_COUNT*9];
    logic [31:0] shadow_pos   [BONE_COUNT*3];
    logic [31:0] shadow_scale [BONE_COUNT];
    position_t   pending_positions [$];

    assign outstanding = pending_positions.size();

    function automatic longint half_up(input longint v);
        return (v + 64'sd32768) >>> 16;
    endfunction

    function automatic longint clamp32(input longint v);
        if (v > 64'sd2147483647) begin
            return 64'sd2147483647;
        end
        if (v < -64'sd2147483648) begin
            return -64'sd2147483648;
        end
        return v;
    endfunction

    function automatic xyz_t bone_transform(input int b, input xyz_t d);
        longint s;
        longint f [3];
        longint acc;
        xyz_t   p;
        s = longint'($signed(shadow_scale[b]));
        for (int c = 0; c < 3; c++) begin
            f[c] = clamp32(half_up(d[c] * s));
        end
        for (int r = 0; r < 3; r++) begin
            acc = longint'($signed(shadow_pos[b*3 + r]));
            for (int c = 0; c < 3; c++) begin
                acc += half_up(f[c] * longint'($signed(shadow_rot[b*9 + r*3 + c])));
            end
            p[r] = clamp32(acc);
        end
        return p;
    endfunction

    function automatic position_t skin_vertex();
        int        major;
        int        minor;
        longint    w;
        xyz_t      dmaj;
        xyz_t      dmin;
        xyz_t      pmaj;
        xyz_t      pmin;
        xyz_t      out;
        position_t pos;
        major   = int'(vtx.primary_bone);
        minor   = int'(vtx.secondary_bone);
        w       = (vtx.blend_factor > WEIGHT_ONE) ? 65536 : longint'(vtx.blend_factor);
        dmaj[0] = vtx.major_dx;
        dmaj[1] = vtx.major_dy;
        dmaj[2] = vtx.major_dz;
        dmin[0] = vtx.minor_dx;
        dmin[1] = vtx.minor_dy;
        dmin[2] = vtx.minor_dz;
        if (major < 0 || major >= BONE_COUNT) begin
            out = dmaj;
        end
        else begin
            pmaj = bone_transform(major, dmaj);
            if (minor < 0 || minor >= BONE_COUNT || w == 65536) begin
                out = pmaj;
            end
            else begin
                pmin = bone_transform(minor, dmin);
                for (int k = 0; k < 3; k++) begin
                    out[k] = clamp32(pmin[k] + half_up((pmaj[k] - pmin[k]) * w));
                end
            end
        end
        pos.x = out[0][31:0];
        pos.y = out[1][31:0];
        pos.z = out[2][31:0];
        return pos;
    endfunction

    always @(posedge clk or negedge rst_n) begin
        position_t want;
        int        b;
        if (!rst_n) begin
            mismatches <= 0;
            pending_positions.delete();
        end
        else begin
            if (res.valid && res.ready) begin
                if (pending_positions.size() == 0) begin
                    if (mismatches < 10) begin
                        $display("Unexpected result transfer: %h %h %h",
                                 res.pos_x, res.pos_y, res.pos_z);
                    end
                    mismatches <= mismatches + 1;
                end
                else begin
                    want = pending_positions.pop_front();
                    if (want.x !== res.pos_x || want.y !== res.pos_y || want.z !== res.pos_z)
                    begin
                        if (mismatches < 10) begin
                            $display("Position mismatch: expected %h %h %h, got %h %h %h",
                                     want.x, want.y, want.z,
                                     res.pos_x, res.pos_y, res.pos_z);
                        end
                        mismatches <= mismatches + 1;
                    end
                end
            end
            if (vtx.valid && vtx.ready) begin
                if (vtx.kind == KIND_WRITE) begin
                    b = int'(vtx.primary_bone);
                    if (b >= 0 && b < BONE_COUNT) begin
                        if (vtx.element_select < 4'd9) begin
                            shadow_rot[b*9 + int'(vtx.element_select)] = vtx.major_dx;
                        end
                        else if (vtx.element_select < ELEM_SCALE) begin
                            shadow_pos[b*3 + int'(vtx.element_select) - 9] = vtx.major_dx;
                        end
                        else if (vtx.element_select == ELEM_SCALE) begin
                            shadow_scale[b] = vtx.major_dx;
                        end
                    end
                end
                else begin
                    pending_positions.push_back(skin_vertex());
                end
            end
        end
    end

endmodule

// ----- sim/two_bone_vertex_skinning_top_tb.sv -----
// ---------------------------------------------------------------------------
// Two-bone vertex skinning testbench
// Loads bone palettes, then streams directed and random vertices and
// palette writes with random gaps and result stalls; a checker compares
// every skinned position against its own prediction.
// ---------------------------------------------------------------------------
module two_bone_vertex_skinning_top_tb;
    import tbvs_pkg::*;

    localparam int BONES       = 64;
    localparam int CYCLE_LIMIT = 400000;

    logic clk;
    logic rst_n;
    logic calm;
    int   mismatches;
    int   outstanding;
    int   cycles = 0;
    int   skins_sent;
    int   writes_sent;
    bit   elem_done [BONES][ELEM_COUNT];

    tbvs_in_if  vtx();
    tbvs_out_if res();

    two_bone_vertex_skinning_top #(.BONE_COUNT(BONES)) dut
    (
        .clk   (clk),
        .rst_n (rst_n),
        .vtx   (vtx),
        .res   (res)
    );

    two_bone_vertex_skinning_checker #(.BONE_COUNT(BONES)) u_checker
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .vtx         (vtx),
        .res         (res),
        .mismatches  (mismatches),
        .outstanding (outstanding)
    );

    initial
    begin
        clk = 1'b0;
        forever
        begin
            #2 clk = ~clk;
        end
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("Verification failed");
            $finish;
        end
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res.ready <= 1'b0;
        end
        else
        begin
            res.ready <= calm || ($urandom_range(99) >= 30);
        end
    end

    function automatic bit bone_ready(input int b);
        for (int e = 0; e < ELEM_COUNT; e++)
        begin
            if (!elem_done[b][e])
            begin
                return 1'b0;
            end
        end
        return 1'b1;
    endfunction

    function automatic logic [31:0] rand_word();
        case ($urandom_range(3))
            0: return $urandom_range(131072) - 65536;
            1: return $urandom_range(1048576) - 524288;
            2: return $urandom();
            default: return $urandom_range(16384) - 8192;
        endcase
    endfunction

    task automatic transfer(input logic kind, input logic signed [6:0] major,
                            input logic signed [6:0] minor, input logic [3:0] sel,
                            input logic [31:0] mx, input logic [31:0] my,
                            input logic [31:0] mz, input logic [31:0] nx,
                            input logic [31:0] ny, input logic [31:0] nz,
                            input logic [16:0] w);
        if (!calm && $urandom_range(99) < 30)
        begin
            vtx.valid <= 1'b0;
            @(posedge clk);
        end
        vtx.valid          <= 1'b1;
        vtx.kind           <= kind;
        vtx.primary_bone   <= major;
        vtx.secondary_bone <= minor;
        vtx.element_select <= sel;
        vtx.major_dx       <= mx;
        vtx.major_dy       <= my;
        vtx.major_dz       <= mz;
        vtx.minor_dx       <= nx;
        vtx.minor_dy       <= ny;
        vtx.minor_dz       <= nz;
        vtx.blend_factor   <= w;
        forever
        begin
            @(negedge clk);
            if (vtx.ready)
            begin
                break;
            end
        end
        @(posedge clk);
        if (kind == KIND_WRITE)
        begin
            writes_sent++;
            if (major >= 0 && sel < ELEM_COUNT)
            begin
                elem_done[major][sel] = 1'b1;
            end
        end
        else
        begin
            skins_sent++;
        end
    endtask

    task automatic write_elem(input int b, input int e, input logic [31:0] value);
        transfer(KIND_WRITE, 7'(b), 7'($urandom()), 4'(e), value, $urandom(), $urandom(),
                 $urandom(), $urandom(), $urandom(), 17'($urandom()));
    endtask

    task automatic skin(input logic signed [6:0] major, input logic signed [6:0] minor,
                        input logic [31:0] mx, input logic [31:0] my, input logic [31:0] mz,
                        input logic [31:0] nx, input logic [31:0] ny, input logic [31:0] nz,
                        input logic [16:0] w);
        transfer(KIND_SKIN, major, minor, 4'($urandom()), mx, my, mz, nx, ny, nz, w);
    endtask

    function automatic logic signed [6:0] pick_bone(input int absent_pct);
        int tries;
        int b;
        if ($urandom_range(99) < absent_pct)
        begin
            return 7'(-1 - int'($urandom_range(63)));
        end
        for (tries = 0; tries < 64; tries++)
        begin
            b = $urandom_range(BONES - 1);
            if (bone_ready(b))
            begin
                return 7'(b);
            end
        end
        return 7'sd0;
    endfunction

    function automatic logic [16:0] pick_weight();
        case ($urandom_range(19))
            0, 1: return WEIGHT_ONE;
            2: return 17'($urandom_range(131071, 65537));
            3: return 17'd0;
            default: return 17'($urandom_range(65535));
        endcase
    endfunction

    initial
    begin
        logic signed [6:0] major;
        logic signed [6:0] minor;
        logic [16:0]       w;
        int                b;
        int                e;
        rst_n              = 1'b0;
        calm               = 1'b0;
        skins_sent         = 0;
        writes_sent        = 0;
        vtx.valid          = 1'b0;
        vtx.kind           = KIND_SKIN;
        vtx.primary_bone   = '0;
        vtx.secondary_bone = '0;
        vtx.element_select = '0;
        vtx.major_dx       = '0;
        vtx.major_dy       = '0;
        vtx.major_dz       = '0;
        vtx.minor_dx       = '0;
        vtx.minor_dy       = '0;
        vtx.minor_dz       = '0;
        vtx.blend_factor   = '0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (e = 0; e < ELEM_COUNT; e++)
        begin
            write_elem(0, e, (e == 0 || e == 4 || e == 8 || e == 12) ? 32'h0001_0000 : 32'h0);
            write_elem(1, e, (e % 2) ? 32'h7fff_ffff : 32'h8000_0000);
            write_elem(2, e, rand_word());
            write_elem(3, e, rand_word());
        end

        skin(-7'sd1, 7'sd0, 32'h7fff_ffff, 32'h8000_0000, 32'h0, 32'h1, 32'h2, 32'h3, 17'd0);
        skin(-7'sd64, -7'sd64, 32'h8000_0000, 32'hffff_ffff, 32'h7fff_ffff,
             32'h0, 32'h0, 32'h0, 17'h1ffff);
        skin(7'sd0, -7'sd1, 32'h0003_8000, 32'hfffe_0000, 32'h0000_0001,
             32'h0, 32'h0, 32'h0, 17'd1000);
        skin(7'sd0, 7'sd2, 32'h0001_0000, 32'h0002_0000, 32'h0003_0000,
             32'h0004_0000, 32'h0005_0000, 32'h0006_0000, 17'd0);
        skin(7'sd2, 7'sd3, $urandom(), $urandom(), $urandom(),
             $urandom(), $urandom(), $urandom(), WEIGHT_ONE);
        skin(7'sd3, 7'sd2, 32'h0000_8000, 32'hffff_8000, 32'h0001_8000,
             32'h0002_0000, 32'h0, 32'h0, 17'h1ffff);
        skin(7'sd1, 7'sd0, 32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff,
             32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000, 17'd32768);
        skin(7'sd0, 7'sd1, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
             32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff, 17'd1);
        skin(7'sd3, 7'sd3, $urandom(), $urandom(), $urandom(),
             $urandom(), $urandom(), $urandom(), 17'd65535);
        transfer(KIND_WRITE, -7'sd1, 7'sd0, ELEM_SCALE, 32'h1234_5678, 32'h0, 32'h0,
                 32'h0, 32'h0, 32'h0, 17'd0);
        transfer(KIND_WRITE, 7'sd0, 7'sd0, 4'd13, 32'hdead_beef, 32'h0, 32'h0,
                 32'h0, 32'h0, 32'h0, 17'd0);
        transfer(KIND_WRITE, 7'sd0, 7'sd0, 4'd14, 32'hdead_beef, 32'h0, 32'h0,
                 32'h0, 32'h0, 32'h0, 17'd0);
        transfer(KIND_WRITE, 7'sd0, 7'sd0, 4'd15, 32'hdead_beef, 32'h0, 32'h0,
                 32'h0, 32'h0, 32'h0, 17'd0);
        skin(7'sd0, 7'sd0, 32'h0001_0000, 32'h0001_0000, 32'h0001_0000,
             32'h0, 32'h0, 32'h0, 17'd16384);
        write_elem(2, 4, 32'hffff_0000);
        skin(7'sd2, -7'sd1, 32'h0001_0000, 32'h0001_0000, 32'h0001_0000,
             32'h0, 32'h0, 32'h0, 17'd0);

        for (int n = 0; n < 1300; n++)
        begin
            calm = (n >= 400 && n < 600);
            if (n == 700)
            begin
                vtx.valid <= 1'b0;
                @(posedge clk);
                while (outstanding != 0)
                begin
                    @(posedge clk);
                end
            end
            if ($urandom_range(99) < 22)
            begin
                if ($urandom_range(99) < 12)
                begin
                    if ($urandom_range(1))
                    begin
                        transfer(KIND_WRITE, 7'(-1 - int'($urandom_range(63))),
                                 7'($urandom()), 4'($urandom()), $urandom(), $urandom(),
                                 $urandom(), $urandom(), $urandom(), $urandom(),
                                 17'($urandom()));
                    end
                    else
                    begin
                        transfer(KIND_WRITE, 7'($urandom_range(63)), 7'($urandom()),
                                 4'($urandom_range(15, 13)), $urandom(), $urandom(),
                                 $urandom(), $urandom(), $urandom(), $urandom(),
                                 17'($urandom()));
                    end
                end
                else
                begin
                    b = $urandom_range(BONES - 1);
                    e = $urandom_range(ELEM_COUNT - 1);
                    write_elem(b, e, rand_word());
                end
            end
            else
            begin
                major = pick_bone(12);
                minor = pick_bone(20);
                w     = pick_weight();
                skin(major, minor, rand_word(), rand_word(), rand_word(),
                     rand_word(), rand_word(), rand_word(), w);
            end
        end
        vtx.valid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0)
        begin
            @(posedge clk);
        end
        repeat (20) @(posedge clk);

        $display("Skinned %0d vertices and issued %0d palette writes.",
                 skins_sent, writes_sent);
        if (mismatches == 0 && outstanding == 0)
        begin
            $display("Verification passed");
        end
        else
        begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule
